>>> sv/huffman_header_code_table_top_macros.svh
// assertion helpers for the huffman header code table
`ifndef HUFFMAN_HEADER_CODE_TABLE_TOP_MACROS_SVH
`define HUFFMAN_HEADER_CODE_TABLE_TOP_MACROS_SVH

// cond holds at an edge, so prop holds at the same edge
`define HHCT_AST_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond holds at an edge, so prop holds at the next edge
`define HHCT_AST_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> sv/hhct_pkg.sv
package hhct_pkg;

    localparam int MAX_LEAVES_DEF   = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int OLEN_W   = 6;
    localparam int TOTAL_W  = 9;
    localparam int STATUS_W = 3;

    localparam logic [7:0] SKIP_RESET = 8'd24;
    localparam logic [7:0] MARK_LEAF  = 8'h31;
    localparam logic [7:0] MARK_MERGE = 8'h30;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_BUILDING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERR_STACK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERR_LIMIT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       byte_value;
        logic [7:0]       entry_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    symbol;
        logic [CODE_W-1:0]   code_bits;
        logic [OLEN_W-1:0]   code_length;
        logic [TOTAL_W-1:0]  leaf_total;
    } out_item_t;

endpackage

>>> sv/huffman_header_code_table_top.sv
// header byte item: result loaded in the finish state; read item: leaf read state, then finish
// (finish at once on a bad index); a merge runs stack reads, then the one-leaf-per-cycle
//   check pass and update pass through the single leaf table ram port pair
// one item at a time: in_stall stays high from accept until the result is loaded
// reset clears phase and counters, skip register to 24; leaf and stack tables are not cleared
// and are read only at entries already written, so no clearing pass follows reset
module huffman_header_code_table_top #(
    parameter int MAX_LEAVES   = hhct_pkg::MAX_LEAVES_DEF,
    parameter int MAX_CODE_LEN = hhct_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hhct_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output hhct_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    `include "huffman_header_code_table_top_macros.svh"

    localparam int LEAF_AW  = $clog2(MAX_LEAVES);
    localparam int CNT_W    = $clog2(MAX_LEAVES + 1);
    localparam int LEN_NEED = $clog2(MAX_CODE_LEN + 1);
    localparam int LEN_W    = (LEN_NEED > hhct_pkg::OLEN_W) ? LEN_NEED : hhct_pkg::OLEN_W;
    localparam int LEAF_DW  = hhct_pkg::SYM_W + hhct_pkg::CODE_W + LEN_W;

    localparam logic [2:0] PH_SKIP      = 3'd0;
    localparam logic [2:0] PH_MARKER    = 3'd1;
    localparam logic [2:0] PH_LEAF      = 3'd2;
    localparam logic [2:0] PH_DONE      = 3'd3;
    localparam logic [2:0] PH_ERR_STACK = 3'd4;
    localparam logic [2:0] PH_ERR_LIMIT = 3'd5;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STK_L  = 3'd1;
    localparam logic [2:0] S_STK_R  = 3'd2;
    localparam logic [2:0] S_STK_C  = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_RD     = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    typedef struct packed {
        logic [hhct_pkg::SYM_W-1:0]  symbol;
        logic [hhct_pkg::CODE_W-1:0] code;
        logic [LEN_W-1:0]            len;
    } leaf_t;

    function automatic logic [hhct_pkg::STATUS_W-1:0] phase_status(input logic [2:0] ph);
        logic [hhct_pkg::STATUS_W-1:0] st;
        unique case (ph)
            PH_DONE:      st = hhct_pkg::ST_COMPLETE;
            PH_ERR_STACK: st = hhct_pkg::ST_ERR_STACK;
            PH_ERR_LIMIT: st = hhct_pkg::ST_ERR_LIMIT;
            default:      st = hhct_pkg::ST_BUILDING;
        endcase
        return st;
    endfunction

    logic [2:0]         fsm_reg, fsm_next;
    logic [2:0]         phase_reg, phase_next;
    logic [7:0]         skip_bytes_reg, skip_bytes_next;
    logic [7:0]         skip_cnt_reg, skip_cnt_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   leaf_cnt_reg, leaf_cnt_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   lstart_reg, lstart_next;
    logic [CNT_W-1:0]   rstart_reg, rstart_next;
    logic               rv_reg, rv_next;
    logic [LEAF_AW-1:0] ridx_reg, ridx_next;
    logic               is_rd_reg, is_rd_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    hhct_pkg::out_item_t out_data_reg, out_data_next;

    logic               in_accept;
    logic               at_marker;

    logic               stk_we;
    logic [LEAF_AW-1:0] stk_waddr;
    logic [LEAF_AW-1:0] stk_wdata;
    logic [LEAF_AW-1:0] stk_raddr;
    logic [LEAF_AW-1:0] stk_rdata;

    logic               leaf_we;
    logic [LEAF_AW-1:0] leaf_waddr;
    leaf_t              leaf_wdata;
    logic [LEAF_AW-1:0] leaf_raddr;
    logic [LEAF_DW-1:0] leaf_rword;
    leaf_t              leaf_rdata;

    assign in_stall   = (fsm_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign leaf_raddr = ptr_reg[LEAF_AW-1:0];
    assign leaf_rdata = leaf_t'(leaf_rword);
    assign at_marker  = (phase_reg == PH_MARKER)
                     || ((phase_reg == PH_SKIP) && (skip_cnt_reg >= skip_bytes_reg));

    hhct_ram #(
        .WIDTH(LEAF_AW),
        .DEPTH(MAX_LEAVES)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    hhct_ram #(
        .WIDTH(LEAF_DW),
        .DEPTH(MAX_LEAVES)
    ) u_leaf_ram (
        .clk  (clk),
        .we   (leaf_we),
        .waddr(leaf_waddr),
        .wdata(LEAF_DW'(leaf_wdata)),
        .raddr(leaf_raddr),
        .rdata(leaf_rword)
    );

    always_comb
    begin
        fsm_next        = fsm_reg;
        phase_next      = phase_reg;
        skip_bytes_next = cfg_wr_en ? cfg_wr_data : skip_bytes_reg;
        skip_cnt_next   = skip_cnt_reg;
        depth_next      = depth_reg;
        leaf_cnt_next   = leaf_cnt_reg;
        ptr_next        = ptr_reg;
        lstart_next     = lstart_reg;
        rstart_next     = rstart_reg;
        rv_next         = 1'b0;
        ridx_next       = ridx_reg;
        is_rd_next      = is_rd_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        stk_we     = 1'b0;
        stk_waddr  = depth_reg[LEAF_AW-1:0];
        stk_wdata  = leaf_cnt_reg[LEAF_AW-1:0];
        stk_raddr  = '0;
        leaf_we    = 1'b0;
        leaf_waddr = leaf_cnt_reg[LEAF_AW-1:0];
        leaf_wdata = '0;

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    is_rd_next = (in_data.opcode == hhct_pkg::OP_READ);
                    fsm_next   = S_FINISH;
                    if (in_data.opcode == hhct_pkg::OP_READ)
                    begin
                        if ({1'b0, in_data.entry_index} >= hhct_pkg::TOTAL_W'(leaf_cnt_reg))
                        begin
                            rd_ok_next = 1'b0;
                        end
                        else
                        begin
                            rd_ok_next = 1'b1;
                            ptr_next   = CNT_W'(in_data.entry_index);
                            fsm_next   = S_RD;
                        end
                    end
                    else
                    begin
                        priority if (phase_reg == PH_SKIP && !at_marker)
                        begin
                            skip_cnt_next = skip_cnt_reg + 8'd1;
                        end
                        else if (at_marker)
                        begin
                            phase_next = PH_MARKER;
                            if (in_data.byte_value == hhct_pkg::MARK_LEAF)
                            begin
                                phase_next = PH_LEAF;
                            end
                            else if (in_data.byte_value == hhct_pkg::MARK_MERGE)
                            begin
                                if (depth_reg == '0)
                                begin
                                    phase_next = PH_ERR_STACK;
                                end
                                else if (depth_reg == CNT_W'(1))
                                begin
                                    depth_next = '0;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    fsm_next = S_STK_L;
                                end
                            end
                        end
                        else if (phase_reg == PH_LEAF)
                        begin
                            if (leaf_cnt_reg >= CNT_W'(MAX_LEAVES))
                            begin
                                phase_next = PH_ERR_LIMIT;
                            end
                            else
                            begin
                                stk_we            = 1'b1;
                                leaf_we           = 1'b1;
                                leaf_wdata.symbol = in_data.byte_value;
                                leaf_cnt_next     = leaf_cnt_reg + CNT_W'(1);
                                depth_next        = depth_reg + CNT_W'(1);
                                phase_next        = PH_MARKER;
                            end
                        end
                        else
                        begin
                            // done or error: byte ignored
                            phase_next = phase_reg;
                        end
                    end
                end
            end

            S_STK_L:
            begin
                stk_raddr = LEAF_AW'(depth_reg - CNT_W'(2));
                fsm_next  = S_STK_R;
            end

            S_STK_R:
            begin
                stk_raddr   = LEAF_AW'(depth_reg - CNT_W'(1));
                lstart_next = CNT_W'(stk_rdata);
                ptr_next    = CNT_W'(stk_rdata);
                fsm_next    = S_STK_C;
            end

            S_STK_C:
            begin
                rstart_next = CNT_W'(stk_rdata);
                fsm_next    = S_CHECK;
            end

            S_CHECK:
            begin
                // reads run one leaf ahead of the length compare
                if (rv_reg && (leaf_rdata.len >= LEN_W'(MAX_CODE_LEN)))
                begin
                    phase_next = PH_ERR_LIMIT;
                    fsm_next   = S_FINISH;
                end
                else if (ptr_reg < leaf_cnt_reg)
                begin
                    ptr_next  = ptr_reg + CNT_W'(1);
                    rv_next   = 1'b1;
                    ridx_next = ptr_reg[LEAF_AW-1:0];
                end
                else if (!rv_reg)
                begin
                    ptr_next = lstart_reg;
                    fsm_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (rv_reg)
                begin
                    leaf_we         = 1'b1;
                    leaf_waddr      = ridx_reg;
                    leaf_wdata      = leaf_rdata;
                    leaf_wdata.len  = leaf_rdata.len + LEN_W'(1);
                    // right subtree leaves get a one at the new top bit
                    if (CNT_W'(ridx_reg) >= rstart_reg)
                    begin
                        leaf_wdata.code = leaf_rdata.code
                                        | (hhct_pkg::CODE_W'(1) << leaf_rdata.len);
                    end
                end
                if (ptr_reg < leaf_cnt_reg)
                begin
                    ptr_next  = ptr_reg + CNT_W'(1);
                    rv_next   = 1'b1;
                    ridx_next = ptr_reg[LEAF_AW-1:0];
                end
                else if (!rv_reg)
                begin
                    depth_next = depth_reg - CNT_W'(1);
                    fsm_next   = S_FINISH;
                end
            end

            S_RD:
            begin
                fsm_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = phase_status(phase_reg);
                    out_data_next.symbol      = '0;
                    out_data_next.code_bits   = '0;
                    out_data_next.code_length = '0;
                    out_data_next.leaf_total  = hhct_pkg::TOTAL_W'(leaf_cnt_reg);
                    if (is_rd_reg && !rd_ok_reg)
                    begin
                        out_data_next.status = hhct_pkg::ST_BAD_INDEX;
                    end
                    else if (is_rd_reg)
                    begin
                        out_data_next.symbol      = leaf_rdata.symbol;
                        out_data_next.code_bits   = leaf_rdata.code;
                        out_data_next.code_length = leaf_rdata.len[hhct_pkg::OLEN_W-1:0];
                    end
                    fsm_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_IDLE;
            phase_reg      <= PH_SKIP;
            skip_bytes_reg <= hhct_pkg::SKIP_RESET;
            skip_cnt_reg   <= '0;
            depth_reg      <= '0;
            leaf_cnt_reg   <= '0;
            rv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            phase_reg      <= phase_next;
            skip_bytes_reg <= skip_bytes_next;
            skip_cnt_reg   <= skip_cnt_next;
            depth_reg      <= depth_next;
            leaf_cnt_reg   <= leaf_cnt_next;
            rv_reg         <= rv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        lstart_reg   <= lstart_next;
        rstart_reg   <= rstart_next;
        ridx_reg     <= ridx_next;
        is_rd_reg    <= is_rd_next;
        rd_ok_reg    <= rd_ok_next;
        out_data_reg <= out_data_next;
    end

    `HHCT_AST_NOW(a_depth_le_leaves, 1'b1, depth_reg <= leaf_cnt_reg,
        "stack deeper than leaf count")
    `HHCT_AST_NOW(a_update_in_range, leaf_we && (fsm_reg == S_UPDATE),
        CNT_W'(leaf_waddr) < leaf_cnt_reg, "code update beyond leaf count")
    `HHCT_AST_NEXT(a_leaves_grow, 1'b1, leaf_cnt_reg >= $past(leaf_cnt_reg),
        "leaf count went down")
    `HHCT_AST_NOW(a_load_from_finish, $rose(out_valid_reg), $past(fsm_reg) == S_FINISH,
        "result loaded outside finish")

endmodule

>>> sv/hhct_ram.sv
module hhct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
